// ----- sv/euler_rotation_matrix_defines.svh -----
// Assertion macros for the Euler rotation matrix block.
`ifndef EULER_ROTATION_MATRIX_DEFINES_SVH
`define EULER_ROTATION_MATRIX_DEFINES_SVH
`ifndef SYNTHESIS
`define ERM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("erm: assertion failed");
`define ERM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("erm: assertion failed");
`else
`define ERM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ERM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- sv/erm_pkg.sv -----
// Shared constants and types for the Euler rotation matrix block.
`default_nettype none

package erm_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAC_BITS  = 14;
    localparam int OUT_BITS   = FRAC_BITS + 2;
    localparam int TURN_BITS  = 32;
    localparam int Q_BITS     = 30;
    localparam int ROUND_SH   = Q_BITS - FRAC_BITS;
    localparam int HALF_R     = (ROUND_SH == 0) ? 0 : (1 << (ROUND_SH - 1));
    localparam int HALF_F     = 1 << (FRAC_BITS - 1);
    localparam int FRAC_ONE   = 1 << FRAC_BITS;
    localparam int NUM_STAGES = 13;

    localparam logic [Q_BITS:0]   Q_ONE     = (Q_BITS + 1)'(1) << Q_BITS;
    localparam logic [Q_BITS-1:0] Q_HALF    = Q_BITS'(1) << (Q_BITS - 1);
    localparam logic [Q_BITS:0]   HALF_PI_Q = (Q_BITS + 1)'(64'd1686629713);

    localparam int SH_72 = Q_BITS + 7;
    localparam int SH_42 = Q_BITS + 6;
    localparam int SH_20 = Q_BITS + 5;
    localparam int SH_6  = Q_BITS + 3;
    localparam int SH_90 = Q_BITS + 7;
    localparam int SH_56 = Q_BITS + 6;
    localparam int SH_30 = Q_BITS + 5;
    localparam int SH_12 = Q_BITS + 4;

    localparam logic [31:0] RCP_72 = 32'(((64'd1 << SH_72) + 64'd71) / 64'd72);
    localparam logic [31:0] RCP_42 = 32'(((64'd1 << SH_42) + 64'd41) / 64'd42);
    localparam logic [31:0] RCP_20 = 32'(((64'd1 << SH_20) + 64'd19) / 64'd20);
    localparam logic [31:0] RCP_6  = 32'(((64'd1 << SH_6) + 64'd5) / 64'd6);
    localparam logic [31:0] RCP_90 = 32'(((64'd1 << SH_90) + 64'd89) / 64'd90);
    localparam logic [31:0] RCP_56 = 32'(((64'd1 << SH_56) + 64'd55) / 64'd56);
    localparam logic [31:0] RCP_30 = 32'(((64'd1 << SH_30) + 64'd29) / 64'd30);
    localparam logic [31:0] RCP_12 = 32'(((64'd1 << SH_12) + 64'd11) / 64'd12);

    typedef enum logic [1:0] {
        QUAD_0,
        QUAD_1,
        QUAD_2,
        QUAD_3
    } t_quad;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] sin_v;
        logic signed [OUT_BITS-1:0] cos_v;
    } t_sincos;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] m00;
        logic signed [OUT_BITS-1:0] m01;
        logic signed [OUT_BITS-1:0] m02;
        logic signed [OUT_BITS-1:0] m10;
        logic signed [OUT_BITS-1:0] m11;
        logic signed [OUT_BITS-1:0] m12;
        logic signed [OUT_BITS-1:0] m20;
        logic signed [OUT_BITS-1:0] m21;
        logic signed [OUT_BITS-1:0] m22;
    } t_matrix;

endpackage

`default_nettype wire

// ----- sv/erm_sincos.sv -----
// Eleven-stage pipelined sine and cosine of a binary angle in Q1.14.
`default_nettype none

module erm_sincos import erm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ANGLE_BITS-1:0] i_angle,
    output t_sincos               o_sc
);

    function automatic logic [Q_BITS-1:0] div_const(input logic [Q_BITS-1:0] n,
                                                     input logic [31:0] m,
                                                     input int sh);
        logic [2*Q_BITS+1:0] prod;
        prod = (2*Q_BITS+2)'(n) * (2*Q_BITS+2)'(m);
        return Q_BITS'(prod >> sh);
    endfunction

    function automatic logic [Q_BITS-1:0] mul_q(input logic [Q_BITS-1:0] a,
                                                 input logic [Q_BITS:0] b);
        logic [2*Q_BITS:0] prod;
        prod = (2*Q_BITS+1)'(a) * (2*Q_BITS+1)'(b);
        return Q_BITS'(prod >> Q_BITS);
    endfunction

    logic [TURN_BITS-1:0] turn;
    logic [Q_BITS-1:0]    rem;
    logic [Q_BITS-1:0]    rem_f;
    logic                 fold;
    logic [2*Q_BITS:0]    x_prod;
    logic [2*Q_BITS-1:0]  x2_prod;

    logic [Q_BITS-1:0] r_x    [0:8];
    logic [Q_BITS-1:0] r_x2   [1:8];
    t_quad             r_quad [0:9];
    logic              r_fold [0:9];

    logic [Q_BITS:0]   r_st2, r_st4, r_st6, r_st8, r_sv9;
    logic [Q_BITS:0]   r_ct2, r_ct4, r_ct6, r_ct8, r_cv9;
    logic [Q_BITS-1:0] r_sp3, r_sp5, r_sp7;
    logic [Q_BITS-1:0] r_cp3, r_cp5, r_cp7;
    t_sincos           r_sc;

    logic [Q_BITS:0]            sw_s, sw_c;
    logic [FRAC_BITS:0]         rnd_s, rnd_c;
    logic signed [OUT_BITS-1:0] pa, pb;
    t_sincos                    n_sc;

    always_comb begin
        turn   = TURN_BITS'(i_angle) << (TURN_BITS - ANGLE_BITS);
        rem    = turn[Q_BITS-1:0];
        fold   = rem > Q_HALF;
        rem_f  = fold ? Q_BITS'(Q_ONE - (Q_BITS + 1)'(rem)) : rem;
        x_prod = (2*Q_BITS+1)'(rem_f) * (2*Q_BITS+1)'(HALF_PI_Q)
               + (2*Q_BITS+1)'(Q_HALF);
        x2_prod = (2*Q_BITS)'(r_x[0]) * (2*Q_BITS)'(r_x[0]) + (2*Q_BITS)'(Q_HALF);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= Q_BITS'(x_prod >> Q_BITS);
            r_quad[0] <= t_quad'(turn[TURN_BITS-1 -: 2]);
            r_fold[0] <= fold;
            r_x2[1]   <= Q_BITS'(x2_prod >> Q_BITS);
            for (int k = 1; k <= 8; k++) begin
                r_x[k] <= r_x[k-1];
            end
            for (int k = 2; k <= 8; k++) begin
                r_x2[k] <= r_x2[k-1];
            end
            for (int k = 1; k <= 9; k++) begin
                r_quad[k] <= r_quad[k-1];
                r_fold[k] <= r_fold[k-1];
            end

            r_st2 <= Q_ONE - (Q_BITS + 1)'(div_const(r_x2[1], RCP_72, SH_72));
            r_ct2 <= Q_ONE - (Q_BITS + 1)'(div_const(r_x2[1], RCP_90, SH_90));
            r_sp3 <= mul_q(r_x2[2], r_st2);
            r_cp3 <= mul_q(r_x2[2], r_ct2);
            r_st4 <= Q_ONE - (Q_BITS + 1)'(div_const(r_sp3, RCP_42, SH_42));
            r_ct4 <= Q_ONE - (Q_BITS + 1)'(div_const(r_cp3, RCP_56, SH_56));
            r_sp5 <= mul_q(r_x2[4], r_st4);
            r_cp5 <= mul_q(r_x2[4], r_ct4);
            r_st6 <= Q_ONE - (Q_BITS + 1)'(div_const(r_sp5, RCP_20, SH_20));
            r_ct6 <= Q_ONE - (Q_BITS + 1)'(div_const(r_cp5, RCP_30, SH_30));
            r_sp7 <= mul_q(r_x2[6], r_st6);
            r_cp7 <= mul_q(r_x2[6], r_ct6);
            r_st8 <= Q_ONE - (Q_BITS + 1)'(div_const(r_sp7, RCP_6, SH_6));
            r_ct8 <= Q_ONE - (Q_BITS + 1)'(div_const(r_cp7, RCP_12, SH_12));
            r_sv9 <= (Q_BITS + 1)'(mul_q(r_x[8], r_st8));
            r_cv9 <= Q_ONE - (Q_BITS + 1)'(mul_q(r_x2[8], r_ct8) >> 1);
            r_sc  <= n_sc;
        end
    end

    // Both series values are non-negative, so rounding acts on magnitudes
    // before the quadrant applies the signs.
    always_comb begin
        sw_s  = r_fold[9] ? r_cv9 : r_sv9;
        sw_c  = r_fold[9] ? r_sv9 : r_cv9;
        rnd_s = (FRAC_BITS + 1)'((32'(sw_s) + 32'(HALF_R)) >> ROUND_SH);
        rnd_c = (FRAC_BITS + 1)'((32'(sw_c) + 32'(HALF_R)) >> ROUND_SH);
        pa    = signed'({1'b0, rnd_s});
        pb    = signed'({1'b0, rnd_c});
        case (r_quad[9])
            QUAD_0: begin
                n_sc.sin_v = pa;
                n_sc.cos_v = pb;
            end
            QUAD_1: begin
                n_sc.sin_v = pb;
                n_sc.cos_v = -pa;
            end
            QUAD_2: begin
                n_sc.sin_v = -pa;
                n_sc.cos_v = -pb;
            end
            QUAD_3: begin
                n_sc.sin_v = -pb;
                n_sc.cos_v = pa;
            end
            default: begin
                n_sc.sin_v = pa;
                n_sc.cos_v = pb;
            end
        endcase
    end

    assign o_sc = r_sc;

endmodule

`default_nettype wire

// ----- sv/euler_rotation_matrix.sv -----
// Top level of the Euler-angle (x-y-z) rotation matrix pipeline.
`default_nettype none
`include "euler_rotation_matrix_defines.svh"
// Each request on the input channel carries three 16-bit binary angles
// (65536 is one full turn) and is taken when i_valid is high and o_stall low.
// Each request yields exactly one result: the nine elements of the rotation
// matrix in signed Q1.14, offered with o_valid and taken when i_stall is low.
// A new request may be taken in every cycle while o_stall is low, so the
// sustained rate is one per cycle. The sine and cosine series run as a
// chain of registered multiply stages, followed by three stages that form
// the products, the sums and the saturation.
// Behind the output register sits a one-entry skid register. When the
// receiver stalls, one more result is caught there; while it is occupied
// o_stall is high and the whole pipeline holds, so nothing is lost.
// A synchronous active-low reset empties the pipeline and both output
// registers; no state is kept between requests.

module euler_rotation_matrix import erm_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [ANGLE_BITS-1:0]      i_angle_x,
    input  logic [ANGLE_BITS-1:0]      i_angle_y,
    input  logic [ANGLE_BITS-1:0]      i_angle_z,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [OUT_BITS-1:0] o_m00,
    output logic signed [OUT_BITS-1:0] o_m01,
    output logic signed [OUT_BITS-1:0] o_m02,
    output logic signed [OUT_BITS-1:0] o_m10,
    output logic signed [OUT_BITS-1:0] o_m11,
    output logic signed [OUT_BITS-1:0] o_m12,
    output logic signed [OUT_BITS-1:0] o_m20,
    output logic signed [OUT_BITS-1:0] o_m21,
    output logic signed [OUT_BITS-1:0] o_m22
);

    localparam int PW = 2 * OUT_BITS;
    localparam logic signed [OUT_BITS:0]   SAT_HI  = (OUT_BITS + 1)'(FRAC_ONE);
    localparam logic signed [OUT_BITS:0]   SAT_LO  = -SAT_HI;
    localparam logic signed [OUT_BITS-1:0] OUT_ONE = OUT_BITS'(FRAC_ONE);

    function automatic logic signed [OUT_BITS-1:0] mul_r(
        input logic signed [OUT_BITS-1:0] a,
        input logic signed [OUT_BITS-1:0] b
    );
        logic signed [PW-1:0] prod;
        logic signed [PW-1:0] bias;
        logic signed [PW-1:0] sum;
        prod = PW'(a) * PW'(b);
        bias = prod[PW-1] ? PW'(HALF_F - 1) : PW'(HALF_F);
        sum  = prod + bias;
        return OUT_BITS'(sum >>> FRAC_BITS);
    endfunction

    function automatic logic signed [OUT_BITS-1:0] sat(input logic signed [OUT_BITS:0] v);
        logic signed [OUT_BITS:0] c;
        c = v;
        if (v > SAT_HI) begin
            c = SAT_HI;
        end else if (v < SAT_LO) begin
            c = SAT_LO;
        end
        return OUT_BITS'(c);
    endfunction

    logic    en;
    logic    xfer;
    t_sincos sc_x, sc_y, sc_z;

    logic [NUM_STAGES-1:0] r_vld;
    logic                  r_out_vld;
    logic                  r_skid_vld;
    t_matrix               r_out;
    t_matrix               r_skid;
    t_matrix               res;

    logic signed [OUT_BITS-1:0] r_sxsy, r_cxsy, r_cycz, r_cysz, r_sxcy, r_cxcy;
    logic signed [OUT_BITS-1:0] r_cxsz, r_cxcz, r_sxsz, r_sxcz, r_nsy, r_cz1, r_sz1;
    logic signed [OUT_BITS-1:0] r_t10, r_t11, r_t20, r_t21;
    logic signed [OUT_BITS-1:0] r_m00_2, r_m01_2, r_m02_2, r_m12_2, r_m22_2;
    logic signed [OUT_BITS-1:0] r_cxsz2, r_cxcz2, r_sxsz2, r_sxcz2;

    assign en      = !r_skid_vld;
    assign xfer    = en && r_vld[NUM_STAGES-1];
    assign o_stall = r_skid_vld;

    erm_sincos u_sc_x (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_angle_x),
        .o_sc    (sc_x)
    );

    erm_sincos u_sc_y (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_angle_y),
        .o_sc    (sc_y)
    );

    erm_sincos u_sc_z (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_angle (i_angle_z),
        .o_sc    (sc_z)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sxsy <= mul_r(sc_x.sin_v, sc_y.sin_v);
            r_cxsy <= mul_r(sc_x.cos_v, sc_y.sin_v);
            r_cycz <= mul_r(sc_y.cos_v, sc_z.cos_v);
            r_cysz <= mul_r(sc_y.cos_v, sc_z.sin_v);
            r_sxcy <= mul_r(sc_x.sin_v, sc_y.cos_v);
            r_cxcy <= mul_r(sc_x.cos_v, sc_y.cos_v);
            r_cxsz <= mul_r(sc_x.cos_v, sc_z.sin_v);
            r_cxcz <= mul_r(sc_x.cos_v, sc_z.cos_v);
            r_sxsz <= mul_r(sc_x.sin_v, sc_z.sin_v);
            r_sxcz <= mul_r(sc_x.sin_v, sc_z.cos_v);
            r_nsy  <= -sc_y.sin_v;
            r_cz1  <= sc_z.cos_v;
            r_sz1  <= sc_z.sin_v;

            r_t10   <= mul_r(r_sxsy, r_cz1);
            r_t11   <= mul_r(r_sxsy, r_sz1);
            r_t20   <= mul_r(r_cxsy, r_cz1);
            r_t21   <= mul_r(r_cxsy, r_sz1);
            r_m00_2 <= r_cycz;
            r_m01_2 <= r_cysz;
            r_m02_2 <= r_nsy;
            r_m12_2 <= r_sxcy;
            r_m22_2 <= r_cxcy;
            r_cxsz2 <= r_cxsz;
            r_cxcz2 <= r_cxcz;
            r_sxsz2 <= r_sxsz;
            r_sxcz2 <= r_sxcz;
        end
    end

    always_comb begin
        res.m00 = sat((OUT_BITS + 1)'(r_m00_2));
        res.m01 = sat((OUT_BITS + 1)'(r_m01_2));
        res.m02 = sat((OUT_BITS + 1)'(r_m02_2));
        res.m10 = sat((OUT_BITS + 1)'(r_t10) - (OUT_BITS + 1)'(r_cxsz2));
        res.m11 = sat((OUT_BITS + 1)'(r_t11) + (OUT_BITS + 1)'(r_cxcz2));
        res.m12 = sat((OUT_BITS + 1)'(r_m12_2));
        res.m20 = sat((OUT_BITS + 1)'(r_t20) + (OUT_BITS + 1)'(r_sxsz2));
        res.m21 = sat((OUT_BITS + 1)'(r_t21) - (OUT_BITS + 1)'(r_sxcz2));
        res.m22 = sat((OUT_BITS + 1)'(r_m22_2));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[NUM_STAGES-2:0], i_valid};
            end
            if (r_skid_vld) begin
                if (!i_stall) begin
                    r_skid_vld <= 1'b0;
                end
            end else if (xfer) begin
                if (r_out_vld && i_stall) begin
                    r_skid_vld <= 1'b1;
                end else begin
                    r_out_vld <= 1'b1;
                end
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (!i_stall) begin
                r_out <= r_skid;
            end
        end else if (xfer) begin
            if (r_out_vld && i_stall) begin
                r_skid <= res;
            end else begin
                r_out <= res;
            end
        end
    end

    assign o_valid = r_out_vld;
    assign o_m00   = r_out.m00;
    assign o_m01   = r_out.m01;
    assign o_m02   = r_out.m02;
    assign o_m10   = r_out.m10;
    assign o_m11   = r_out.m11;
    assign o_m12   = r_out.m12;
    assign o_m20   = r_out.m20;
    assign o_m21   = r_out.m21;
    assign o_m22   = r_out.m22;

    `ERM_ASSERT_IMP(a_skid_needs_out, i_clk, i_rst_n, r_skid_vld, r_out_vld)
    `ERM_ASSERT_NXT(a_skid_drains, i_clk, i_rst_n, r_skid_vld && !i_stall, r_out_vld && !r_skid_vld)
    `ERM_ASSERT_NXT(a_pipe_holds, i_clk, i_rst_n, !en, $stable(r_vld))
    `ERM_ASSERT_IMP(a_m11_range, i_clk, i_rst_n, o_valid, (o_m11 <= OUT_ONE) && (o_m11 >= -OUT_ONE))

endmodule

`default_nettype wire

// ----- dv/euler_rotation_matrix_tb.sv -----
// Self-checking testbench for the Euler-angle rotation matrix pipeline.
module euler_rotation_matrix_tb;
    import erm_pkg::*;

    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     HOLD_CYCLES  = 400;
    localparam int     NUM_DIRECTED = 20;
    localparam longint Q30_UNIT     = 64'sd1 << 30;
    localparam longint RAD_QUARTER  = 64'sd1686629713;

    localparam logic signed [OUT_BITS-1:0] POS_ONE = OUT_BITS'(FRAC_ONE);
    localparam logic signed [OUT_BITS-1:0] NEG_ONE = OUT_BITS'(-FRAC_ONE);
    localparam logic signed [OUT_BITS-1:0] NIL     = '0;

    localparam t_matrix M_IDENT = '{POS_ONE, NIL, NIL, NIL, POS_ONE, NIL, NIL, NIL, POS_ONE};
    localparam t_matrix M_X90   = '{POS_ONE, NIL, NIL, NIL, NIL, POS_ONE, NIL, NEG_ONE, NIL};
    localparam t_matrix M_X180  = '{POS_ONE, NIL, NIL, NIL, NEG_ONE, NIL, NIL, NIL, NEG_ONE};
    localparam t_matrix M_X270  = '{POS_ONE, NIL, NIL, NIL, NIL, NEG_ONE, NIL, POS_ONE, NIL};
    localparam t_matrix M_Y90   = '{NIL, NIL, NEG_ONE, NIL, POS_ONE, NIL, POS_ONE, NIL, NIL};
    localparam t_matrix M_Z90   = '{NIL, POS_ONE, NIL, NEG_ONE, NIL, NIL, NIL, NIL, POS_ONE};

    typedef struct packed {
        logic [ANGLE_BITS-1:0] ax;
        logic [ANGLE_BITS-1:0] ay;
        logic [ANGLE_BITS-1:0] az;
        logic                  known;
        t_matrix               m;
    } t_stim_row;

    localparam t_stim_row STIM_TABLE [NUM_DIRECTED] = '{
        '{16'h0000, 16'h0000, 16'h0000, 1'b1, M_IDENT},
        '{16'h4000, 16'h0000, 16'h0000, 1'b1, M_X90},
        '{16'h8000, 16'h0000, 16'h0000, 1'b1, M_X180},
        '{16'hC000, 16'h0000, 16'h0000, 1'b1, M_X270},
        '{16'h0000, 16'h4000, 16'h0000, 1'b1, M_Y90},
        '{16'h0000, 16'h0000, 16'h4000, 1'b1, M_Z90},
        '{16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{16'h2000, 16'h2000, 16'h2000, 1'b0, '0},
        '{16'h2001, 16'h2001, 16'h2001, 1'b0, '0},
        '{16'h1FFF, 16'h1FFF, 16'h1FFF, 1'b0, '0},
        '{16'h3FFF, 16'hBFFF, 16'h7FFF, 1'b0, '0},
        '{16'h4001, 16'h8001, 16'hC001, 1'b0, '0},
        '{16'h0001, 16'h0001, 16'h0001, 1'b0, '0},
        '{16'hE000, 16'h6000, 16'hA000, 1'b0, '0},
        '{16'h5555, 16'hAAAA, 16'h5555, 1'b0, '0},
        '{16'hAAAA, 16'h5555, 16'hAAAA, 1'b0, '0},
        '{16'h0000, 16'h8000, 16'h4000, 1'b0, '0},
        '{16'hFFFF, 16'h0000, 16'h8000, 1'b0, '0},
        '{16'h1234, 16'hABCD, 16'hF00F, 1'b0, '0},
        '{16'h6000, 16'hE000, 16'h2000, 1'b0, '0}
    };

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_stall;
    logic [ANGLE_BITS-1:0]      i_angle_x;
    logic [ANGLE_BITS-1:0]      i_angle_y;
    logic [ANGLE_BITS-1:0]      i_angle_z;
    logic                       o_valid;
    logic                       i_stall;
    logic signed [OUT_BITS-1:0] o_m00, o_m01, o_m02;
    logic signed [OUT_BITS-1:0] o_m10, o_m11, o_m12;
    logic signed [OUT_BITS-1:0] o_m20, o_m21, o_m22;

    t_matrix matrix_q [$];
    int      requests_sent   = 0;
    int      results_checked = 0;
    int      failures        = 0;
    int      cycle_count     = 0;
    bit      long_hold       = 1'b0;
    bit      quiet           = 1'b0;

    euler_rotation_matrix uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_angle_x (i_angle_x),
        .i_angle_y (i_angle_y),
        .i_angle_z (i_angle_z),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_m00     (o_m00),
        .o_m01     (o_m01),
        .o_m02     (o_m02),
        .o_m10     (o_m10),
        .o_m11     (o_m11),
        .o_m12     (o_m12),
        .o_m20     (o_m20),
        .o_m21     (o_m21),
        .o_m22     (o_m22)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic longint round_half_away(input longint v, input int sh);
        longint mag;
        if (sh == 0) begin
            return v;
        end
        mag = (v < 0) ? -v : v;
        mag = (mag + (64'sd1 << (sh - 1))) >>> sh;
        return (v < 0) ? -mag : mag;
    endfunction

    function automatic void sin_cos_q14(input logic [ANGLE_BITS-1:0] ang,
                                        output longint s, output longint c);
        logic [31:0] turn;
        t_quad       quad;
        bit          fold;
        longint      r, x, x2, t, sv, cv;
        turn = 32'(ang) << (32 - ANGLE_BITS);
        quad = t_quad'(turn[31:30]);
        r    = longint'(turn[29:0]);
        fold = r > (64'sd1 << 29);
        if (fold) begin
            r = Q30_UNIT - r;
        end
        x  = (r * RAD_QUARTER + (64'sd1 << 29)) >>> 30;
        x2 = (x * x + (64'sd1 << 29)) >>> 30;

        t  = Q30_UNIT - x2 / 72;
        t  = Q30_UNIT - ((x2 * t) >>> 30) / 42;
        t  = Q30_UNIT - ((x2 * t) >>> 30) / 20;
        t  = Q30_UNIT - ((x2 * t) >>> 30) / 6;
        sv = (x * t) >>> 30;

        t  = Q30_UNIT - x2 / 90;
        t  = Q30_UNIT - ((x2 * t) >>> 30) / 56;
        t  = Q30_UNIT - ((x2 * t) >>> 30) / 30;
        t  = Q30_UNIT - ((x2 * t) >>> 30) / 12;
        cv = Q30_UNIT - ((x2 * t) >>> 30) / 2;

        if (fold) begin
            t  = sv;
            sv = cv;
            cv = t;
        end
        case (quad)
            QUAD_0: begin s = sv;  c = cv;  end
            QUAD_1: begin s = cv;  c = -sv; end
            QUAD_2: begin s = -sv; c = -cv; end
            default: begin s = -cv; c = sv; end
        endcase
        s = round_half_away(s, Q_BITS - FRAC_BITS);
        c = round_half_away(c, Q_BITS - FRAC_BITS);
    endfunction

    function automatic longint mul_q(input longint a, input longint b);
        return round_half_away(a * b, FRAC_BITS);
    endfunction

    function automatic logic signed [OUT_BITS-1:0] clamp_unit(input longint v);
        if (v > FRAC_ONE) begin
            v = FRAC_ONE;
        end
        if (v < -FRAC_ONE) begin
            v = -FRAC_ONE;
        end
        return OUT_BITS'(v);
    endfunction

    function automatic t_matrix rotation_matrix(input logic [ANGLE_BITS-1:0] ax,
                                                input logic [ANGLE_BITS-1:0] ay,
                                                input logic [ANGLE_BITS-1:0] az);
        longint  sx, cx, sy, cy, sz, cz;
        t_matrix m;
        sin_cos_q14(ax, sx, cx);
        sin_cos_q14(ay, sy, cy);
        sin_cos_q14(az, sz, cz);
        m.m00 = clamp_unit(mul_q(cy, cz));
        m.m01 = clamp_unit(mul_q(cy, sz));
        m.m02 = clamp_unit(-sy);
        m.m10 = clamp_unit(mul_q(mul_q(sx, sy), cz) - mul_q(cx, sz));
        m.m11 = clamp_unit(mul_q(mul_q(sx, sy), sz) + mul_q(cx, cz));
        m.m12 = clamp_unit(mul_q(sx, cy));
        m.m20 = clamp_unit(mul_q(mul_q(cx, sy), cz) + mul_q(sx, sz));
        m.m21 = clamp_unit(mul_q(mul_q(cx, sy), sz) - mul_q(sx, cz));
        m.m22 = clamp_unit(mul_q(cx, cy));
        return m;
    endfunction

    function automatic logic [ANGLE_BITS-1:0] random_angle();
        logic [ANGLE_BITS-1:0] a;
        if ($urandom_range(0, 3) == 0) begin
            a = (ANGLE_BITS'($urandom_range(0, 7)) << (ANGLE_BITS - 3))
                + ANGLE_BITS'($urandom_range(0, 6)) - ANGLE_BITS'(3);
        end else begin
            a = ANGLE_BITS'($urandom());
        end
        return a;
    endfunction

    task automatic send_request(input logic [ANGLE_BITS-1:0] ax,
                                input logic [ANGLE_BITS-1:0] ay,
                                input logic [ANGLE_BITS-1:0] az,
                                input logic known, input t_matrix m);
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_angle_x <= ax;
        i_angle_y <= ay;
        i_angle_z <= az;
        do @(posedge i_clk); while (o_stall);
        matrix_q.push_back(known ? m : rotation_matrix(ax, ay, az));
        requests_sent++;
    endtask

    task automatic idle_requests(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    task automatic send_random(input int count, input bit gaps);
        repeat (count) begin
            send_request(random_angle(), random_angle(), random_angle(), 1'b0, '0);
            if (gaps && $urandom_range(0, 5) == 0) begin
                idle_requests($urandom_range(1, 17));
            end
        end
    endtask

    task automatic wait_drained();
        while (matrix_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                i_stall <= 1'b0;
                long_hold = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_matrix seen;
        t_matrix want;
        if (i_rst_n && o_valid && !i_stall) begin
            seen = {o_m00, o_m01, o_m02, o_m10, o_m11, o_m12, o_m20, o_m21, o_m22};
            if (matrix_q.size() == 0) begin
                $error("result with no request outstanding");
                failures++;
            end else begin
                want = matrix_q.pop_front();
                results_checked++;
                for (int i = 0; i < 9; i++) begin
                    if (seen[(8 - i) * OUT_BITS +: OUT_BITS] !==
                        want[(8 - i) * OUT_BITS +: OUT_BITS]) begin
                        $error("m%0d%0d: expected %0d, actual %0d", i / 3, i % 3,
                               $signed(want[(8 - i) * OUT_BITS +: OUT_BITS]),
                               $signed(seen[(8 - i) * OUT_BITS +: OUT_BITS]));
                        failures++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_angle_x = '0;
        i_angle_y = '0;
        i_angle_z = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < NUM_DIRECTED; k++) begin
            send_request(STIM_TABLE[k].ax, STIM_TABLE[k].ay, STIM_TABLE[k].az,
                         STIM_TABLE[k].known, STIM_TABLE[k].m);
            if ($urandom_range(0, 3) == 0) begin
                idle_requests($urandom_range(1, 17));
            end
        end

        send_random(300, 1'b1);
        idle_requests(1);
        wait_drained();

        // The receiver holds off while requests keep coming, so the pipeline fills.
        long_hold = 1'b1;
        send_random(80, 1'b0);
        send_random(320, 1'b1);

        quiet = 1'b1;
        send_random(150, 1'b0);
        idle_requests(1);
        wait_drained();
        repeat (3 * NUM_STAGES) @(posedge i_clk);

        $display("Run summary: %0d angle requests sent, %0d rotation matrices compared, %0d errors.",
                 requests_sent, results_checked, failures);
        $display("Covered quarter and half turns, octant folds, full-turn wrap, random gaps, %0d-cycle hold.",
                 HOLD_CYCLES);
        if (failures == 0 && matrix_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
